/* src/isfms_pkg.sv */
// Package with shared types and codes for the integer stream filter/map/sum block.
`timescale 1ns / 1ps
package isfms_pkg;
  localparam int unsigned W = 64;
  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_SUM    = 2'd2;
  localparam logic [2:0] OP_1 = 3'd1;
  localparam logic [2:0] OP_2 = 3'd2;
  localparam logic [2:0] OP_3 = 3'd3;
  localparam logic [2:0] OP_4 = 3'd4;
  localparam logic [2:0] OP_5 = 3'd5;
  localparam logic [2:0] OP_6 = 3'd6;
  localparam logic [2:0] OP_7 = 3'd7;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_OP   = 2'd1;
  localparam logic [1:0] REG_A    = 2'd2;
  localparam logic [1:0] REG_B    = 2'd3;
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

/* src/int_stream_filter_map_sum_core.sv */
// Top level: bit-serial filter, map and sum engine for signed 64-bit streams.
// After an accept the element passes a prepare state, 64 bit-serial steps and a finish state.
// The 64 steps come from a shared shift register datapath (add, multiply, divide one bit each).
// A result is registered in an output state before out_tvalid rises; the next element is accepted
// only after the result is taken, so the block holds one element at a time.
// Elements that yield no result return to idle from the finish state and allow the next accept.
// Reset (rst_n low, synchronous) clears the configuration registers, the running sum and the control.
`timescale 1ns / 1ps
module int_stream_filter_map_sum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // element
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result_value
  output logic        out_tuser,  // kept
  output logic        out_tlast   // last_result
);
  localparam int unsigned W = isfms_pkg::W;

  logic [1:0]  mode_r;
  logic [2:0]  op_r;
  logic [63:0] a_r, b_r, sum_r;
  isfms_pkg::state_t st_r;
  logic [6:0]  cnt_r;
  logic [63:0] x_r, sh_r, acc_r, q_r, d_r, rem_r;
  logic        carry_r, last_r, nneg_r, dneg_r;
  logic [63:0] ov_r;
  logic        okept_r, olast_r, ovalid_r;

  // One serial step: a one-bit full add, and a single 65-bit subtract for the divider.
  logic [64:0] trial;
  logic [63:0] remsh;
  logic        sbit, sc;
  assign remsh = {rem_r[62:0], q_r[63]};
  assign trial = {1'b0, remsh} - {1'b0, d_r};
  assign sbit  = acc_r[0] ^ sh_r[0] ^ carry_r;
  assign sc    = (acc_r[0] & sh_r[0]) | (carry_r & (acc_r[0] ^ sh_r[0]));

  logic is_div, is_mul;
  assign is_div = (mode_r == isfms_pkg::MODE_MAP && op_r == isfms_pkg::OP_4) ||
                  (mode_r == isfms_pkg::MODE_FILTER && op_r == isfms_pkg::OP_1);
  assign is_mul = mode_r == isfms_pkg::MODE_MAP && op_r == isfms_pkg::OP_1;

  assign in_tready  = st_r == isfms_pkg::ST_IDLE && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = ov_r;
  assign out_tuser  = okept_r;
  assign out_tlast  = olast_r;

  logic [63:0] qf, rf;
  logic        pass, lt_xa, eq_xa;
  always_comb begin
    qf = (nneg_r ^ dneg_r) ? 64'd0 - q_r : q_r;
    rf = nneg_r ? 64'd0 - rem_r : rem_r;
    eq_xa = x_r == a_r;
    lt_xa = $signed(x_r) < $signed(a_r);
    case (op_r)
      isfms_pkg::OP_1: pass = a_r != 64'd0 && rf == b_r;
      isfms_pkg::OP_2: pass = !lt_xa && !eq_xa;
      isfms_pkg::OP_3: pass = !lt_xa;
      isfms_pkg::OP_4: pass = lt_xa;
      isfms_pkg::OP_5: pass = lt_xa || eq_xa;
      isfms_pkg::OP_6: pass = eq_xa;
      isfms_pkg::OP_7: pass = !eq_xa;
      default:         pass = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; op_r <= '0; a_r <= '0; b_r <= '0; sum_r <= '0;
      st_r <= isfms_pkg::ST_IDLE; cnt_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          isfms_pkg::REG_MODE: mode_r <= cfg_wdata[1:0];
          isfms_pkg::REG_OP:   op_r   <= cfg_wdata[2:0];
          isfms_pkg::REG_A:    a_r    <= cfg_wdata;
          isfms_pkg::REG_B:    b_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        isfms_pkg::ST_IDLE: if (in_tvalid && in_tready) begin
          x_r <= in_tdata; last_r <= in_tlast; st_r <= isfms_pkg::ST_PREP;
        end
        isfms_pkg::ST_PREP: begin
          nneg_r <= x_r[63]; dneg_r <= a_r[63];
          d_r   <= a_r[63] ? 64'd0 - a_r : a_r;
          rem_r <= '0; cnt_r <= '0;
          if (is_mul) begin
            acc_r <= '0; sh_r <= x_r; q_r <= a_r; carry_r <= 1'b0;
          end else if (mode_r == isfms_pkg::MODE_SUM) begin
            acc_r <= sum_r; sh_r <= x_r; carry_r <= 1'b0;
            q_r   <= x_r[63] ? 64'd0 - x_r : x_r;
          end else begin
            acc_r <= x_r;
            sh_r  <= (op_r == isfms_pkg::OP_3) ? ~a_r : a_r;
            carry_r <= op_r == isfms_pkg::OP_3;
            q_r   <= x_r[63] ? 64'd0 - x_r : x_r;
          end
          st_r <= isfms_pkg::ST_RUN;
        end
        isfms_pkg::ST_RUN: begin
          cnt_r <= cnt_r + 7'd1;
          if (is_div) begin
            if (!trial[64]) rem_r <= trial[63:0]; else rem_r <= remsh;
            q_r <= {q_r[62:0], ~trial[64]};
          end else if (is_mul) begin
            // Shift-add: one multiplier bit per step, low bit of a_r first.
            if (q_r[0]) acc_r <= acc_r + sh_r;
            sh_r <= {sh_r[62:0], 1'b0};
            q_r  <= {1'b0, q_r[63:1]};
          end else begin
            acc_r <= {sbit, acc_r[63:1]}; sh_r <= {1'b0, sh_r[63:1]}; carry_r <= sc;
          end
          if (cnt_r == 7'(W - 1)) st_r <= isfms_pkg::ST_FIN;
        end
        isfms_pkg::ST_FIN: begin
          if (last_r) sum_r <= '0;
          unique case (mode_r)
            isfms_pkg::MODE_FILTER: begin
              if (pass || last_r) begin
                ov_r <= pass ? x_r : 64'd0; okept_r <= pass; olast_r <= last_r;
                st_r <= isfms_pkg::ST_OUT;
              end else begin
                st_r <= isfms_pkg::ST_IDLE;
              end
            end
            isfms_pkg::MODE_MAP: begin
              if (is_div) ov_r <= (a_r == 64'd0) ? 64'd0 : qf;
              else if (op_r == isfms_pkg::OP_2 || op_r == isfms_pkg::OP_3 ||
                       is_mul) ov_r <= acc_r;
              else ov_r <= x_r;
              okept_r <= 1'b1; olast_r <= last_r; st_r <= isfms_pkg::ST_OUT;
            end
            isfms_pkg::MODE_SUM: begin
              if (!last_r) begin
                sum_r <= acc_r; st_r <= isfms_pkg::ST_IDLE;
              end else begin
                ov_r <= acc_r; okept_r <= 1'b1; olast_r <= 1'b1;
                st_r <= isfms_pkg::ST_OUT;
              end
            end
            default: st_r <= isfms_pkg::ST_IDLE;
          endcase
        end
        isfms_pkg::ST_OUT: begin
          ovalid_r <= 1'b1; st_r <= isfms_pkg::ST_IDLE;
        end
        default: st_r <= isfms_pkg::ST_IDLE;
      endcase
    end
  end

  // The serial counter only advances while a step is running.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != isfms_pkg::ST_RUN && st_r != isfms_pkg::ST_FIN |=> $stable(cnt_r) ||
    st_r == isfms_pkg::ST_RUN) else $error("serial counter moved outside a run");
  // A pending result blocks new input.
  a_blk: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("input accepted while result pending");
  // A marker without data always closes a run.
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !okept_r |-> olast_r) else $error("unkept result not last");
  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(ov_r)) else $error("result dropped");
endmodule
